// ===== design/sal_pkg.sv =====
package sal_pkg;

  // Request modes carried in the mode field of an input beat.
  localparam logic [2:0] MODE_GET    = 3'd0;
  localparam logic [2:0] MODE_SET    = 3'd1;
  localparam logic [2:0] MODE_APPEND = 3'd2;
  localparam logic [2:0] MODE_INSERT = 3'd3;
  localparam logic [2:0] MODE_REMOVE = 3'd4;
  localparam logic [2:0] MODE_CLEAR  = 3'd5;
  localparam logic [2:0] MODE_DROP   = 3'd6;
  localparam logic [2:0] MODE_SWAP   = 3'd7;

  // Wide enough for a position or a count at the largest supported depth.
  localparam int POS_BITS = 9;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_WRITE,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SWAP
  } cell_op_t;

  // Command broadcast to every cell of the row at the same time.
  typedef struct packed {
    cell_op_t op;
    pos_t     pos_a;
    pos_t     pos_b;
    pos_t     count;
  } cell_cmd_t;

endpackage

// ===== design/sal_if.sv =====
interface sal_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [3:0] index;
  logic [3:0] second_index;
  logic [31:0] item;

  modport source (output valid, output mode, output index, output second_index,
                  output item, input ready);
  modport sink (input valid, input mode, input index, input second_index,
                input item, output ready);
endinterface

interface sal_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] read_item;
  logic [4:0]  item_count;

  modport source (output valid, output ok, output read_item, output item_count,
                  input ready);
  modport sink (input valid, input ok, input read_item, input item_count,
                output ready);
endinterface

// ===== design/sal_cell.sv =====
module sal_cell #(
  parameter int IDX       = 0,
  parameter int ITEM_BITS = 32
) (
  input  logic                  clk,
  input  sal_pkg::cell_cmd_t    cmd,
  input  logic [ITEM_BITS-1:0]  wdata,
  input  logic [ITEM_BITS-1:0]  data_a,
  input  logic [ITEM_BITS-1:0]  data_b,
  input  logic [ITEM_BITS-1:0]  low_q,
  input  logic [ITEM_BITS-1:0]  high_q,
  output logic [ITEM_BITS-1:0]  q
);

  localparam sal_pkg::pos_t MY_POS = sal_pkg::POS_BITS'(IDX);

  logic [ITEM_BITS-1:0] data_r;
  logic [ITEM_BITS-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      sal_pkg::CELL_WRITE: begin
        if (MY_POS == cmd.pos_a) data_nxt = wdata;
      end
      sal_pkg::CELL_INSERT: begin
        // The insert point takes the new item; cells above it, up to the old count, take their lower neighbor's item.
        if (MY_POS == cmd.pos_a) begin
          data_nxt = wdata;
        end else if (MY_POS > cmd.pos_a && MY_POS <= cmd.count) begin
          data_nxt = low_q;
        end
      end
      sal_pkg::CELL_REMOVE: begin
        if (MY_POS >= cmd.pos_a && (MY_POS + 1'b1) < cmd.count) data_nxt = high_q;
      end
      sal_pkg::CELL_SWAP: begin
        if (MY_POS == cmd.pos_a) begin
          data_nxt = data_b;
        end else if (MY_POS == cmd.pos_b) begin
          data_nxt = data_a;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== design/shifting_array_list.sv =====
// Each accepted request's result is registered and held as a result beat until it is taken.
// Throughput: one request per cycle while the result side takes each beat as it appears.
// The item row updates all cells at once, so insert and remove finish in the same cycle.
// Reset (rst_n low, synchronous) empties the list, sets the capacity register to 16
// and drops any pending result; item contents are not reset and are unreadable until written.
module shifting_array_list #(
  parameter int DEPTH     = 16,
  parameter int ITEM_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  sal_in_if.sink          in_ch,
  sal_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [4:0]      cfg_wdata
);

  // Count needs to hold DEPTH itself; addresses need only reach DEPTH-1.
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam sal_pkg::pos_t DEPTH_POS = sal_pkg::POS_BITS'(DEPTH);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [4:0]    cap_r;

  logic          out_valid_r;
  logic          ok_r;
  logic [31:0]   read_r;
  logic [4:0]    cnt_out_r;

  logic          accept;
  logic          ok_nxt;
  logic [31:0]   read_nxt;
  sal_pkg::pos_t cnt_pos;
  sal_pkg::pos_t cnt_after;
  sal_pkg::pos_t pos_a;
  sal_pkg::pos_t pos_b;
  sal_pkg::pos_t cap_pos;
  sal_pkg::pos_t eff_cap;
  logic          room;
  logic          a_live;
  logic          b_live;

  sal_pkg::cell_cmd_t cmd;

  logic [ITEM_BITS-1:0]  cell_q [DEPTH];
  logic [ITEM_BITS-1:0]  data_a;
  logic [ITEM_BITS-1:0]  data_b;
  logic [ITEM_BITS-1:0]  wdata;
  logic [ITEM_BITS+31:0] item_ext;
  logic [ITEM_BITS+31:0] rd_ext;

  // A new request is taken whenever the result register is empty or is being
  // emptied in this cycle, so the list runs one beat per cycle under no stall.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Incoming items are cut or zero-extended to the stored item width.
  assign item_ext = {{ITEM_BITS{1'b0}}, in_ch.item};
  assign wdata    = item_ext[ITEM_BITS-1:0];

  // All range checks run in one common width that covers any built depth.
  assign cnt_pos = sal_pkg::POS_BITS'(count_r);
  assign pos_a   = sal_pkg::POS_BITS'(in_ch.index);
  assign pos_b   = sal_pkg::POS_BITS'(in_ch.second_index);
  assign cap_pos = sal_pkg::POS_BITS'(cap_r);

  // The effective capacity is the register value, saturated at the built depth.
  assign eff_cap = (cap_pos < DEPTH_POS) ? cap_pos : DEPTH_POS;
  assign room    = cnt_pos < eff_cap;
  assign a_live  = pos_a < cnt_pos;
  assign b_live  = pos_b < cnt_pos;

  // Both read ports pick a cell directly; they feed get and swap.
  assign data_a = cell_q[pos_a[AW-1:0]];
  assign data_b = cell_q[pos_b[AW-1:0]];
  assign rd_ext = {32'd0, data_a};

  // Decode the request into a row command, the success flag, the read item and the new count.
  always_comb begin
    cmd.op    = sal_pkg::CELL_IDLE;
    cmd.pos_a = pos_a;
    cmd.pos_b = pos_b;
    cmd.count = cnt_pos;
    ok_nxt    = 1'b0;
    read_nxt  = 32'd0;
    cnt_after = cnt_pos;
    unique case (in_ch.mode)
      sal_pkg::MODE_GET: begin
        if (a_live) begin
          ok_nxt   = 1'b1;
          read_nxt = rd_ext[31:0];
        end
      end
      sal_pkg::MODE_SET: begin
        if (a_live) begin
          ok_nxt = 1'b1;
          cmd.op = sal_pkg::CELL_WRITE;
        end
      end
      sal_pkg::MODE_APPEND: begin
        if (room) begin
          ok_nxt    = 1'b1;
          cmd.op    = sal_pkg::CELL_WRITE;
          cmd.pos_a = cnt_pos;
          cnt_after = cnt_pos + 1'b1;
        end
      end
      sal_pkg::MODE_INSERT: begin
        if (room && pos_a <= cnt_pos) begin
          ok_nxt    = 1'b1;
          cmd.op    = sal_pkg::CELL_INSERT;
          cnt_after = cnt_pos + 1'b1;
        end
      end
      sal_pkg::MODE_REMOVE: begin
        if (a_live) begin
          ok_nxt    = 1'b1;
          cmd.op    = sal_pkg::CELL_REMOVE;
          cnt_after = cnt_pos - 1'b1;
        end
      end
      sal_pkg::MODE_CLEAR: begin
        // Clearing only resets the count; old items become unreachable.
        ok_nxt    = 1'b1;
        cnt_after = '0;
      end
      sal_pkg::MODE_DROP: begin
        if (cnt_pos != '0) begin
          ok_nxt    = 1'b1;
          cnt_after = cnt_pos - 1'b1;
        end
      end
      default: begin
        // Swap: both positions must hold live items; swapping with itself is harmless.
        if (a_live && b_live) begin
          ok_nxt = 1'b1;
          cmd.op = sal_pkg::CELL_SWAP;
        end
      end
    endcase
    if (!accept) cmd.op = sal_pkg::CELL_IDLE;
  end

  assign count_nxt = accept ? CW'(cnt_after) : count_r;

  // The row of cells. Each cell sees its two neighbors; the ends see zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_BITS-1:0] low_q;
    logic [ITEM_BITS-1:0] high_q;
    if (i == 0) begin : g_low_end
      assign low_q = '0;
    end else begin : g_low
      assign low_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_high_end
      assign high_q = '0;
    end else begin : g_high
      assign high_q = cell_q[i+1];
    end
    sal_cell #(
      .IDX       (i),
      .ITEM_BITS (ITEM_BITS)
    ) u_cell (
      .clk    (clk),
      .cmd    (cmd),
      .wdata  (wdata),
      .data_a (data_a),
      .data_b (data_b),
      .low_q  (low_q),
      .high_q (high_q),
      .q      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= 5'd16;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; it only changes when a new request is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r      <= ok_nxt;
      read_r    <= read_nxt;
      cnt_out_r <= cnt_after[4:0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = ok_r;
  assign out_ch.read_item  = read_r;
  assign out_ch.item_count = cnt_out_r;

  // The count can never run past the built depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(DEPTH) >= count_r)
    else $error("item count exceeds depth");

  // A rejected request leaves the count untouched.
  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !ok_nxt |=> $stable(count_r))
    else $error("rejected request changed the count");

  // A successful append grows the list by exactly one.
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ok_nxt && in_ch.mode == sal_pkg::MODE_APPEND
    |=> count_r == $past(count_r) + 1'b1)
    else $error("append did not grow the list by one");

  // A taken clear empties the list.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.mode == sal_pkg::MODE_CLEAR |=> count_r == '0)
    else $error("clear left items in the list");

  // The result beat reports the count the list holds after that request.
  a_count_reported: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_ch.item_count == sal_pkg::POS_BITS'(count_r) % 32)
    else $error("reported count disagrees with the list");

endmodule

// ===== sim/shifting_array_list_tb.sv =====
`timescale 1ns / 1ps

module shifting_array_list_tb;

  localparam int LIST_DEPTH   = 16;
  localparam int PHASE_ITEMS  = 155;
  localparam int HOLD_CYCLES  = 90;
  localparam int DRAIN_LIMIT  = 4000;

  // One result beat as the block should present it.
  typedef struct packed {
    logic        ok;
    logic [31:0] read_item;
    logic [4:0]  item_count;
  } list_answer_t;

  // The scoreboard keeps its own copy of the list and of the capacity
  // register. Every accepted request beat is replayed on that copy, and the
  // answer it yields waits in order until the block's result beat comes.
  class list_scoreboard;
    logic [31:0]  entries [LIST_DEPTH];
    int unsigned  held;
    int unsigned  capacity;
    list_answer_t awaited_answers [$];
    int unsigned  mismatches;

    function void reset_state();
      foreach (entries[k]) entries[k] = '0;
      held = 0;
      capacity = 16;
      mismatches = 0;
      awaited_answers.delete();
    endfunction

    function void note_request(logic [2:0] mode, logic [3:0] pos, logic [3:0] pos2,
                               logic [31:0] item);
      list_answer_t answer;
      logic [31:0]  spare;
      int unsigned  room;
      int           k;
      answer.ok = 1'b0;
      answer.read_item = '0;
      // A register value above the built depth saturates at the depth.
      room = (capacity < LIST_DEPTH) ? capacity : LIST_DEPTH;
      case (mode)
        sal_pkg::MODE_GET: begin
          if (pos < held) begin
            answer.read_item = entries[pos];
            answer.ok = 1'b1;
          end
        end
        sal_pkg::MODE_SET: begin
          if (pos < held) begin
            entries[pos] = item;
            answer.ok = 1'b1;
          end
        end
        sal_pkg::MODE_APPEND: begin
          if (held < room) begin
            entries[held] = item;
            held++;
            answer.ok = 1'b1;
          end
        end
        sal_pkg::MODE_INSERT: begin
          if (pos <= held && held < room) begin
            for (k = held; k > pos; k--) entries[k] = entries[k-1];
            entries[pos] = item;
            held++;
            answer.ok = 1'b1;
          end
        end
        sal_pkg::MODE_REMOVE: begin
          if (pos < held) begin
            for (k = pos; k + 1 < held; k++) entries[k] = entries[k+1];
            held--;
            answer.ok = 1'b1;
          end
        end
        sal_pkg::MODE_CLEAR: begin
          held = 0;
          answer.ok = 1'b1;
        end
        sal_pkg::MODE_DROP: begin
          if (held > 0) begin
            held--;
            answer.ok = 1'b1;
          end
        end
        default: begin
          if (pos < held && pos2 < held) begin
            spare = entries[pos];
            entries[pos] = entries[pos2];
            entries[pos2] = spare;
            answer.ok = 1'b1;
          end
        end
      endcase
      answer.item_count = held[4:0];
      awaited_answers.push_back(answer);
    endfunction

    function void check_result(logic ok, logic [31:0] read_item, logic [4:0] item_count);
      list_answer_t answer;
      if (awaited_answers.size() == 0) begin
        if (mismatches < 10)
          $display("result beat with nothing awaited: ok=%b read_item=%h item_count=%0d",
                   ok, read_item, item_count);
        mismatches++;
        return;
      end
      answer = awaited_answers.pop_front();
      if (ok !== answer.ok || read_item !== answer.read_item ||
          item_count !== answer.item_count) begin
        if (mismatches < 10)
          $display("mismatch: exp ok=%b read_item=%h count=%0d, got ok=%b read_item=%h count=%0d",
                   answer.ok, answer.read_item, answer.item_count,
                   ok, read_item, item_count);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  sal_in_if  in_ch ();
  sal_out_if out_ch ();

  list_scoreboard board;

  // Set by the stimulus to ask the result side for one long hold-off; the
  // result side clears it when the hold-off is over.
  bit hold_off_request = 1'b0;
  // In the last part of the run neither side idles.
  bit quiet = 1'b0;

  shifting_array_list #(
    .DEPTH     (LIST_DEPTH),
    .ITEM_BITS (32)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Every result beat is taken at the edge where valid and ready are both
  // high. The signals are read in the active region right after the edge, so
  // they still hold the values that the block itself sampled.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      board.check_result(out_ch.ok, out_ch.read_item, out_ch.item_count);
  end

  // Result side: ready comes in random bursts with stalls of random length
  // between them, and once a long hold-off so that the block fills up and stops
  // taking request beats.
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Offers one request beat and returns at the edge where it is taken.
  // Valid is left high, so a following request goes out back to back.
  task automatic send_request(input logic [2:0] mode, input logic [3:0] pos,
                              input logic [3:0] pos2, input logic [31:0] item);
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.index        <= pos;
    in_ch.second_index <= pos2;
    in_ch.item         <= item;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_request(mode, pos, pos2, item);
  endtask

  // A gap on the request side. The payload carries junk while valid is low.
  task automatic idle_gap(input int unsigned cycles);
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= 3'($urandom);
    in_ch.index        <= 4'($urandom);
    in_ch.second_index <= 4'($urandom);
    in_ch.item         <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops offering beats and waits until every awaited answer has arrived.
  // Every request gives exactly one result, so the block is idle then.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.awaited_answers.size() != 0);
  endtask

  // The capacity register is only written while the block is idle.
  task automatic write_capacity(input logic [4:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.capacity = value;
  endtask

  // The mode mix leans toward growing or toward shrinking, so the list
  // keeps running between empty and full.
  function automatic logic [2:0] pick_mode(input bit grow);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return sal_pkg::MODE_GET;
    if (roll < 25) return sal_pkg::MODE_SET;
    if (grow) begin
      if (roll < 50) return sal_pkg::MODE_APPEND;
      if (roll < 70) return sal_pkg::MODE_INSERT;
      if (roll < 80) return sal_pkg::MODE_REMOVE;
      if (roll < 82) return sal_pkg::MODE_CLEAR;
      if (roll < 90) return sal_pkg::MODE_DROP;
    end else begin
      if (roll < 33) return sal_pkg::MODE_APPEND;
      if (roll < 40) return sal_pkg::MODE_INSERT;
      if (roll < 65) return sal_pkg::MODE_REMOVE;
      if (roll < 68) return sal_pkg::MODE_CLEAR;
      if (roll < 90) return sal_pkg::MODE_DROP;
    end
    return sal_pkg::MODE_SWAP;
  endfunction

  // Mostly a position that is in range for the current list, sometimes any
  // position at all so that the rejections get their share.
  function automatic logic [3:0] pick_index(input int unsigned span);
    if (span == 0 || $urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
    if (span > LIST_DEPTH) span = LIST_DEPTH;
    return 4'($urandom_range(0, span - 1));
  endfunction

  function automatic logic [31:0] pick_item();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 32'h0000_0000;
    if (roll == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic random_phase(input int unsigned items, input logic [4:0] capacity,
                              input bit with_hold, input bit with_pause);
    logic [2:0]  mode;
    logic [3:0]  pos;
    logic [3:0]  pos2;
    int unsigned i;
    write_capacity(capacity);
    for (i = 0; i < items; i++) begin
      mode = pick_mode(((i / 40) % 2) == 0);
      pos  = pick_index((mode == sal_pkg::MODE_INSERT) ? board.held + 1 : board.held);
      pos2 = (mode == sal_pkg::MODE_SWAP) ? pick_index(board.held) : 4'($urandom);
      send_request(mode, pos, pos2, pick_item());
      // The request side keeps offering beats through the long hold-off.
      if (with_hold && i == items / 3) hold_off_request = 1'b1;
      if (with_pause && i == (2 * items) / 3)
        wait_drained();
      else if (!quiet && $urandom_range(0, 5) == 0)
        idle_gap($urandom_range(1, 13));
    end
  endtask

  initial begin
    int unsigned guard;
    board = new();
    board.reset_state();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= sal_pkg::MODE_GET;
    in_ch.index        <= '0;
    in_ch.second_index <= '0;
    in_ch.item         <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Everything on an empty list is rejected except clear and the adds.
    send_request(sal_pkg::MODE_GET,    4'd0, 4'd0, 32'h0);
    send_request(sal_pkg::MODE_DROP,   4'd0, 4'd0, 32'h0);
    send_request(sal_pkg::MODE_REMOVE, 4'd0, 4'd0, 32'h0);
    send_request(sal_pkg::MODE_SWAP,   4'd0, 4'd0, 32'h0);
    send_request(sal_pkg::MODE_SET,    4'd0, 4'd0, 32'hDEAD_BEEF);
    // Build a short list with the extreme item values, including an insert
    // at the head and one at the tail position that acts as an append.
    send_request(sal_pkg::MODE_APPEND, 4'd0, 4'd0, 32'hFFFF_FFFF);
    send_request(sal_pkg::MODE_APPEND, 4'd0, 4'd0, 32'h0000_0000);
    send_request(sal_pkg::MODE_INSERT, 4'd0, 4'd0, 32'hA5A5_A5A5);
    send_request(sal_pkg::MODE_INSERT, 4'd3, 4'd0, 32'h5A5A_5A5A);
    // An insert past the tail is rejected.
    send_request(sal_pkg::MODE_INSERT, 4'd5, 4'd0, 32'h1111_1111);
    send_request(sal_pkg::MODE_GET,    4'd0, 4'd0, 32'h0);
    send_request(sal_pkg::MODE_GET,    4'd3, 4'd0, 32'h0);
    send_request(sal_pkg::MODE_GET,    4'd4, 4'd0, 32'h0);
    send_request(sal_pkg::MODE_SET,    4'd1, 4'd0, 32'h1234_5678);
    // A swap of an entry with itself succeeds and changes nothing.
    send_request(sal_pkg::MODE_SWAP,   4'd2, 4'd2, 32'h0);
    send_request(sal_pkg::MODE_SWAP,   4'd0, 4'd3, 32'h0);
    send_request(sal_pkg::MODE_SWAP,   4'd0, 4'd9, 32'h0);
    send_request(sal_pkg::MODE_REMOVE, 4'd1, 4'd0, 32'h0);
    send_request(sal_pkg::MODE_REMOVE, 4'd2, 4'd0, 32'h0);
    send_request(sal_pkg::MODE_GET,    4'd15, 4'd15, 32'h0);
    // After a clear the old entries are no longer readable.
    send_request(sal_pkg::MODE_CLEAR,  4'd0, 4'd0, 32'h0);
    send_request(sal_pkg::MODE_GET,    4'd0, 4'd0, 32'h0);

    // A small capacity: the third add finds the list full.
    write_capacity(5'd2);
    send_request(sal_pkg::MODE_APPEND, 4'd0, 4'd0, 32'hCAFE_0001);
    send_request(sal_pkg::MODE_APPEND, 4'd0, 4'd0, 32'hCAFE_0002);
    send_request(sal_pkg::MODE_INSERT, 4'd0, 4'd0, 32'hCAFE_0003);
    // Capacity lowered below the count: the held items stay usable, adds
    // fail until the count has come down below the capacity.
    write_capacity(5'd1);
    send_request(sal_pkg::MODE_GET,    4'd1, 4'd0, 32'h0);
    send_request(sal_pkg::MODE_APPEND, 4'd0, 4'd0, 32'hCAFE_0004);
    send_request(sal_pkg::MODE_REMOVE, 4'd0, 4'd0, 32'h0);
    send_request(sal_pkg::MODE_DROP,   4'd0, 4'd0, 32'h0);
    send_request(sal_pkg::MODE_APPEND, 4'd0, 4'd0, 32'hCAFE_0005);
    // With the register at zero no add can succeed.
    write_capacity(5'd0);
    send_request(sal_pkg::MODE_APPEND, 4'd0, 4'd0, 32'hCAFE_0006);
    send_request(sal_pkg::MODE_INSERT, 4'd0, 4'd0, 32'hCAFE_0007);

    // Random phases under several capacities, among them zero, one, the
    // built depth and values above it that must saturate.
    random_phase(PHASE_ITEMS, 5'd16, 1'b0, 1'b0);
    random_phase(PHASE_ITEMS, 5'd31, 1'b1, 1'b0);
    random_phase(PHASE_ITEMS, 5'd1,  1'b0, 1'b0);
    random_phase(PHASE_ITEMS, 5'd0,  1'b0, 1'b0);
    random_phase(PHASE_ITEMS, 5'd8,  1'b0, 1'b1);
    random_phase(PHASE_ITEMS, 5'd17, 1'b0, 1'b0);
    random_phase(PHASE_ITEMS, 5'd2,  1'b0, 1'b0);
    random_phase(PHASE_ITEMS, 5'd16, 1'b0, 1'b0);
    random_phase(PHASE_ITEMS, 5'($urandom_range(3, 15)), 1'b0, 1'b0);
    random_phase(PHASE_ITEMS, 5'd5,  1'b0, 1'b0);
    random_phase(PHASE_ITEMS, 5'd31, 1'b0, 1'b0);
    quiet = 1'b1;
    random_phase(PHASE_ITEMS, 5'd16, 1'b0, 1'b0);

    // Let the last result beats come in, then wait on for a while so that a
    // stray beat would still be seen.
    in_ch.valid <= 1'b0;
    for (guard = 0; guard < DRAIN_LIMIT && board.awaited_answers.size() != 0; guard++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.awaited_answers.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== shifting_array_list.f =====
design/sal_pkg.sv
design/sal_if.sv
design/sal_cell.sv
design/shifting_array_list.sv
sim/shifting_array_list_tb.sv
